// File: design/eight_channel_dma_controller_core_assert.svh
// assertion macros for the dma controller core
`ifndef EIGHT_CHANNEL_DMA_CONTROLLER_CORE_ASSERT_SVH
`define EIGHT_CHANNEL_DMA_CONTROLLER_CORE_ASSERT_SVH
// implication checked on every edge outside reset
`define DMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dma check failed");
// next-cycle implication
`define DMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dma check failed");
`endif

// File: design/ecdma_pkg.sv
// shared types and constants of the dma controller core
package ecdma_pkg;
  localparam int NumChannels = 8;
  localparam int ChW = 3;
  localparam int QDepth = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [15:0] ENABLE_ADDR = 16'h420B;
  localparam logic [15:0] B_BASE = 16'h2100;

  localparam logic [3:0] OFF_CTRL  = 4'h0;
  localparam logic [3:0] OFF_DEST  = 4'h1;
  localparam logic [3:0] OFF_SRCL  = 4'h2;
  localparam logic [3:0] OFF_SRCH  = 4'h3;
  localparam logic [3:0] OFF_BANK  = 4'h4;
  localparam logic [3:0] OFF_SIZEL = 4'h5;
  localparam logic [3:0] OFF_SIZEH = 4'h6;
  localparam logic [3:0] OFF_IBANK = 4'h7;
  localparam logic [3:0] OFF_TABL  = 4'h8;
  localparam logic [3:0] OFF_TABH  = 4'h9;
  localparam logic [3:0] OFF_LINE  = 4'hA;

  typedef enum logic [1:0] {
    OP_NONE, OP_WRITE, OP_READ, OP_TICK
  } op_e;

  // classified item passed from front to back
  typedef struct packed {
    op_e        op;
    logic       is_enable;
    logic       mapped;
    logic [2:0] ch;
    logic [3:0] off;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        xfer_valid;
    logic [2:0]  xfer_channel;
    logic [23:0] bus_a_address;
    logic [15:0] bus_b_address;
    logic        b_to_a;
    logic        xfer_last;
  } res_t;

  function automatic logic [1:0] unit_offset(input logic [2:0] mode, input logic [1:0] u);
    logic [1:0] r;
    r = 2'd0;
    case (mode)
      3'd1, 3'd5: r = {1'b0, u[0]};
      3'd3, 3'd7: r = {1'b0, u[1]};
      3'd4:       r = u;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction
endpackage

// File: design/eight_channel_dma_controller_core.sv
// Eight-channel DMA register file and byte sequencer. Items enter on s_axis:
// tuser is the command (0 write, 1 read, 2 tick), tdata the register address
// and write byte. Every item yields exactly one result on m_axis. A tick moves
// one byte for the lowest active channel. An item passes from a two-entry queue
// behind the decode stage into the result register of the back end; one item
// per cycle flows while m_axis_tready does not stall the result register.
module eight_channel_dma_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // reg_address[15:0], write_data[23:16]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // read_data, xfer_channel, bus_a_address, bus_b_address
  output logic [1:0]  m_axis_tuser,  // xfer_valid, b_to_a
  output logic        m_axis_tlast   // xfer_last
);
  import ecdma_pkg::*;

  `include "eight_channel_dma_controller_core_assert.svh"

  logic  q_valid, q_ready;
  op_t   q_op;
  res_t  res;

  ecdma_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tuser_i(s_axis_tuser), .s_tdata_i(s_axis_tdata),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_op_o(q_op)
  );

  ecdma_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_op_i(q_op),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.bus_b_address, res.bus_a_address, res.xfer_channel,
                         res.read_data};
  assign m_axis_tuser = {res.b_to_a, res.xfer_valid};
  assign m_axis_tlast = res.xfer_last;

  `DMA_ASSERT_IMP(a_last_needs_valid, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
  `DMA_ASSERT_IMP(a_xfer_no_read, m_axis_tvalid && m_axis_tuser[0],
                  m_axis_tdata[7:0] == 8'd0)
  `DMA_ASSERT_NXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

// File: design/ecdma_front.sv
// front end: accepts items, decodes them and queues them for the back end
module ecdma_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [1:0]           s_tuser_i,
  input  logic [23:0]          s_tdata_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output ecdma_pkg::op_t       q_op_o
);
  import ecdma_pkg::*;

  op_t        mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  op_t        dec;
  logic [15:0] addr;
  logic       push, pop;

  assign addr = s_tdata_i[15:0];

  always_comb begin
    dec.data = s_tdata_i[23:16];
    dec.ch = addr[6:4];
    dec.off = addr[3:0];
    dec.is_enable = (addr == ENABLE_ADDR);
    dec.mapped = ((addr & 16'hFF80) == 16'h4300) && ({29'd0, addr[6:4]} < NumChannels)
                 && (addr[3:0] <= OFF_LINE);
    case (s_tuser_i)
      CMD_WRITE: dec.op = OP_WRITE;
      CMD_READ:  dec.op = OP_READ;
      CMD_TICK:  dec.op = OP_TICK;
      default:   dec.op = OP_NONE;
    endcase
  end

  assign s_tready_o = (cnt_q != 2'(QDepth));
  assign push = s_tvalid_i && s_tready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_op_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: design/ecdma_back.sv
// back end: channel register file and transfer sequencer
module ecdma_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  ecdma_pkg::op_t       q_op_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output ecdma_pkg::res_t      res_o
);
  import ecdma_pkg::*;

  logic [7:0]  ctl_q   [NumChannels];
  logic [7:0]  dest_q  [NumChannels];
  logic [15:0] src_q   [NumChannels];
  logic [7:0]  bank_q  [NumChannels];
  logic [15:0] cnt_q   [NumChannels];
  logic [7:0]  ibank_q [NumChannels];
  logic [15:0] tab_q   [NumChannels];
  logic [7:0]  line_q  [NumChannels];
  logic [1:0]  unit_q  [NumChannels];
  logic [NumChannels-1:0] act_q;
  logic        ov_q;
  res_t        res_q, res_d;
  logic        take, found;
  logic [2:0]  sel;
  logic [15:0] cnt_dec;
  logic [7:0]  rd;

  assign q_ready_o = !ov_q || m_tready_i;
  assign take = q_valid_i && q_ready_o;
  assign m_tvalid_o = ov_q;
  assign res_o = res_q;

  // lowest active channel
  always_comb begin
    found = 1'b0;
    sel = 3'd0;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (act_q[i]) begin
        found = 1'b1;
        sel = 3'(i);
      end
    end
  end

  assign cnt_dec = cnt_q[sel] - 16'd1;

  always_comb begin
    rd = 8'd0;
    case (q_op_i.off)
      OFF_CTRL:  rd = ctl_q[q_op_i.ch];
      OFF_DEST:  rd = dest_q[q_op_i.ch];
      OFF_SRCL:  rd = src_q[q_op_i.ch][7:0];
      OFF_SRCH:  rd = src_q[q_op_i.ch][15:8];
      OFF_BANK:  rd = bank_q[q_op_i.ch];
      OFF_SIZEL: rd = cnt_q[q_op_i.ch][7:0];
      OFF_SIZEH: rd = cnt_q[q_op_i.ch][15:8];
      OFF_IBANK: rd = ibank_q[q_op_i.ch];
      OFF_TABL:  rd = tab_q[q_op_i.ch][7:0];
      OFF_TABH:  rd = tab_q[q_op_i.ch][15:8];
      OFF_LINE:  rd = line_q[q_op_i.ch];
      default:   rd = 8'd0;
    endcase
  end

  always_comb begin
    res_d = '0;
    if (q_op_i.op == OP_READ && q_op_i.mapped) res_d.read_data = rd;
    if (q_op_i.op == OP_TICK && found) begin
      res_d.xfer_valid = 1'b1;
      res_d.xfer_channel = sel;
      res_d.bus_a_address = {bank_q[sel], src_q[sel]};
      res_d.bus_b_address = B_BASE | {8'd0, dest_q[sel] +
                            {6'd0, unit_offset(ctl_q[sel][2:0], unit_q[sel])}};
      res_d.b_to_a = ctl_q[sel][7];
      res_d.xfer_last = (cnt_dec == 16'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      res_q <= '0;
      act_q <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        ctl_q[i] <= '0; dest_q[i] <= '0; src_q[i] <= '0; bank_q[i] <= '0;
        cnt_q[i] <= '0; ibank_q[i] <= '0; tab_q[i] <= '0; line_q[i] <= '0;
        unit_q[i] <= '0;
      end
    end else begin
      if (take) begin
        ov_q <= 1'b1;
        res_q <= res_d;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
      if (take && q_op_i.op == OP_WRITE) begin
        if (q_op_i.is_enable) begin
          for (int i = 0; i < NumChannels; i++) begin
            if (q_op_i.data[i]) begin
              act_q[i] <= 1'b1;
              unit_q[i] <= 2'd0;
            end
          end
        end else if (q_op_i.mapped) begin
          case (q_op_i.off)
            OFF_CTRL:  ctl_q[q_op_i.ch] <= q_op_i.data;
            OFF_DEST:  dest_q[q_op_i.ch] <= q_op_i.data;
            OFF_SRCL:  src_q[q_op_i.ch][7:0] <= q_op_i.data;
            OFF_SRCH:  src_q[q_op_i.ch][15:8] <= q_op_i.data;
            OFF_BANK:  bank_q[q_op_i.ch] <= q_op_i.data;
            OFF_SIZEL: cnt_q[q_op_i.ch][7:0] <= q_op_i.data;
            OFF_SIZEH: cnt_q[q_op_i.ch][15:8] <= q_op_i.data;
            OFF_IBANK: ibank_q[q_op_i.ch] <= q_op_i.data;
            OFF_TABL:  tab_q[q_op_i.ch][7:0] <= q_op_i.data;
            OFF_TABH:  tab_q[q_op_i.ch][15:8] <= q_op_i.data;
            OFF_LINE:  line_q[q_op_i.ch] <= q_op_i.data;
            default:   ;
          endcase
        end
      end
      if (take && q_op_i.op == OP_TICK && found) begin
        if (!ctl_q[sel][3]) begin
          src_q[sel] <= ctl_q[sel][4] ? src_q[sel] - 16'd1 : src_q[sel] + 16'd1;
        end
        cnt_q[sel] <= cnt_dec;
        unit_q[sel] <= unit_q[sel] + 2'd1;
        if (cnt_dec == 16'd0) act_q[sel] <= 1'b0;
      end
    end
  end
endmodule
